// ===== sv/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

  localparam int unsigned VAL_W  = 32;
  localparam int unsigned OCC_W  = 7;
  localparam int unsigned CAP_W  = 7;
  localparam int unsigned APB_AW = 2;
  localparam int unsigned APB_DW = 32;

  localparam logic [CAP_W-1:0]  CAP_RESET         = 7'd64;
  localparam logic [APB_AW-1:0] REG_CAPACITY_ADDR = 2'd0;

  typedef enum logic {
    ACT_ENQ = 1'b0,
    ACT_DEQ = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    logic push;
    logic pop;
  } cell_cmd_t;

endpackage

// ===== sv/spq_cell.sv =====
// One slot of the sorted chain: holds a value and trades with its neighbors.
`timescale 1ns / 1ps

module spq_cell
  import spq_pkg::*;
(
  input  logic                    clk_i,
  input  cell_cmd_t               cmd_i,
  input  logic                    occ_i,
  input  logic signed [VAL_W-1:0] new_value_i,
  input  logic                    prev_take_i,
  input  logic signed [VAL_W-1:0] prev_value_i,
  input  logic signed [VAL_W-1:0] next_value_i,
  output logic                    take_o,
  output logic signed [VAL_W-1:0] value_o
);

  logic signed [VAL_W-1:0] val_q, val_d;

  // new value belongs at or below this slot
  assign take_o  = !occ_i || (val_q >= new_value_i);
  assign value_o = val_q;

  always_comb begin
    val_d = val_q;
    if (cmd_i.push) begin
      if (prev_take_i) begin
        val_d = prev_value_i;
      end else if (take_o) begin
        val_d = new_value_i;
      end
    end else if (cmd_i.pop) begin
      val_d = next_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

// ===== sv/sorted_priority_queue_top.sv =====
// Top level of the sorted min-priority queue built as a chain of compare-and-shift cells.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+-------------------------------------------
//  command   | start_i / busy_o      | action_i, value_in_i
//  result    | done_o (one cycle)    | status_o, value_out_o, occupancy_o
//  config    | APB psel/penable      | paddr, pwdata, prdata
//
//  One command per cycle; each result is registered and appears in the cycle after its transfer.
//  Every cell compares and shifts in the same cycle, so the chain sets the rate.
//  busy_o stays low; the receiver takes done_o every cycle it is high.
//  Reset empties the queue and sets the capacity register to 64; no clearing pass.
`timescale 1ns / 1ps

module sorted_priority_queue_top
  import spq_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic                    action_i,
  input  logic signed [VAL_W-1:0] value_in_i,
  output logic                    done_o,
  output logic [1:0]              status_o,
  output logic signed [VAL_W-1:0] value_out_o,
  output logic [OCC_W-1:0]        occupancy_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [APB_AW-1:0]       paddr,
  input  logic [APB_DW-1:0]       pwdata,
  output logic [APB_DW-1:0]       prdata,
  output logic                    pready
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic [CAP_W-1:0] cap_q;
  logic [CNT_W-1:0] count_q, count_d;

  logic                    done_q;
  status_e                 status_q, status_d;
  logic signed [VAL_W-1:0] value_out_q, value_out_d;
  logic [OCC_W-1:0]        occ_q;

  logic      fire, full, empty;
  cell_cmd_t cmd;
  logic [CMP_W-1:0] cnt_ext_q, cnt_ext_d, cap_ext;

  logic signed [VAL_W-1:0] cell_val  [CAPACITY];
  logic                    cell_take [CAPACITY];

  // configuration
  assign pready = 1'b1;
  assign prdata = (paddr == REG_CAPACITY_ADDR) ? APB_DW'(cap_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == REG_CAPACITY_ADDR)) begin
      cap_q <= pwdata[CAP_W-1:0];
    end
  end

  // command decode
  assign busy_o    = 1'b0;
  assign fire      = start_i && !busy_o;
  assign cnt_ext_q = CMP_W'(count_q);
  assign cap_ext   = CMP_W'(cap_q);
  assign full      = (cnt_ext_q >= cap_ext) || (count_q >= CNT_W'(CAPACITY));
  assign empty     = (count_q == '0);

  assign cmd.push = fire && (action_e'(action_i) == ACT_ENQ) && !full;
  assign cmd.pop  = fire && (action_e'(action_i) == ACT_DEQ) && !empty;

  always_comb begin
    count_d     = count_q;
    status_d    = ST_OK;
    value_out_d = '0;
    unique case (action_e'(action_i))
      ACT_ENQ: begin
        if (full) begin
          status_d = ST_OVERFLOW;
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end
      ACT_DEQ: begin
        if (empty) begin
          status_d = ST_UNDERFLOW;
        end else begin
          count_d     = count_q - CNT_W'(1);
          value_out_d = cell_val[0];
        end
      end
      default: status_d = ST_OK;
    endcase
  end

  assign cnt_ext_d = CMP_W'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= fire;
      if (fire) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q    <= status_d;
      value_out_q <= value_out_d;
      occ_q       <= cnt_ext_d[OCC_W-1:0];
    end
  end

  assign done_o      = done_q;
  assign status_o    = status_q;
  assign value_out_o = value_out_q;
  assign occupancy_o = occ_q;

  // cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                    prev_take;
    logic signed [VAL_W-1:0] prev_val, next_val;

    if (i == 0) begin : g_head
      assign prev_take = 1'b0;
      assign prev_val  = '0;
    end else begin : g_body
      assign prev_take = cell_take[i-1];
      assign prev_val  = cell_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_val = '0;
    end else begin : g_link
      assign next_val = cell_val[i+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .occ_i        (count_q > CNT_W'(i)),
      .new_value_i  (value_in_i),
      .prev_take_i  (prev_take),
      .prev_value_i (prev_val),
      .next_value_i (next_val),
      .take_o       (cell_take[i]),
      .value_o      (cell_val[i])
    );

    if (i < CAPACITY - 1) begin : g_order_chk
      a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
        (count_q > CNT_W'(i + 1)) |-> (cell_val[i] <= cell_val[i+1]))
        else $error("queue order broken");
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> done_o)
    else $error("transfer without result");

  a_ovf_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_OVERFLOW)) |-> $stable(count_q))
    else $error("overflow changed the count");

  a_udf_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_UNDERFLOW)) |-> (count_q == '0))
    else $error("underflow on a non-empty queue");

endmodule

// ===== bench/spq_result_checker.sv =====
// Checker for the sorted priority queue: predicts each command result and compares it.
`timescale 1ns / 1ps

module spq_result_checker
  import spq_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic                    busy_i,
  input  logic                    action_i,
  input  logic signed [VAL_W-1:0] value_in_i,
  input  logic                    done_i,
  input  logic [1:0]              status_i,
  input  logic signed [VAL_W-1:0] value_out_i,
  input  logic [OCC_W-1:0]        occupancy_i,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [APB_AW-1:0]       paddr,
  input  logic [APB_DW-1:0]       pwdata,
  input  logic [APB_DW-1:0]       prdata,
  input  logic                    pready,
  output int                      fail_count_o,
  output int                      pending_o,
  output int                      results_o,
  output int                      overflows_o,
  output int                      underflows_o
);

  typedef struct packed {
    status_e                 status;
    logic signed [VAL_W-1:0] value;
    logic [OCC_W-1:0]        occ;
  } outcome_t;

  logic signed [VAL_W-1:0] held [CAPACITY];
  int unsigned             held_n;
  logic [CAP_W-1:0]        cap_reg;
  outcome_t                expected_results [$];
  outcome_t                want;
  int                      fails      = 0;
  int                      results    = 0;
  int                      overflows  = 0;
  int                      underflows = 0;

  assign fail_count_o = fails;
  assign pending_o    = expected_results.size();
  assign results_o    = results;
  assign overflows_o  = overflows;
  assign underflows_o = underflows;

  function automatic outcome_t apply_command(action_e act, logic signed [VAL_W-1:0] v);
    outcome_t    r;
    int unsigned limit;
    int unsigned pos;
    int unsigned k;
    r.status = ST_OK;
    r.value  = '0;
    limit    = (cap_reg < CAPACITY) ? cap_reg : CAPACITY;
    if (act == ACT_ENQ) begin
      if (held_n >= limit) begin
        r.status = ST_OVERFLOW;
      end else begin
        pos = 0;
        while (pos < held_n && v > held[pos]) pos++;
        for (k = held_n; k > pos; k--) held[k] = held[k-1];
        held[pos] = v;
        held_n++;
      end
    end else if (held_n == 0) begin
      r.status = ST_UNDERFLOW;
    end else begin
      r.value = held[0];
      for (k = 1; k < held_n; k++) held[k-1] = held[k];
      held_n--;
    end
    r.occ = held_n[OCC_W-1:0];
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      held_n  = 0;
      cap_reg = CAP_RESET;
      expected_results.delete();
    end else begin
      if (start_i && !busy_i) begin
        expected_results.push_back(apply_command(action_e'(action_i), value_in_i));
      end
      if (done_i) begin
        results++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, status %0d value %0d occupancy %0d",
                   $time, status_i, value_out_i, occupancy_i);
          fails++;
        end else begin
          want = expected_results.pop_front();
          if (want.status == ST_OVERFLOW) overflows++;
          if (want.status == ST_UNDERFLOW) underflows++;
          if (status_i !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, status_i);
            fails++;
          end
          if (value_out_i !== want.value) begin
            $display("%0t: value_out mismatch, expected %0d, actual %0d",
                     $time, want.value, value_out_i);
            fails++;
          end
          if (occupancy_i !== want.occ) begin
            $display("%0t: occupancy mismatch, expected %0d, actual %0d",
                     $time, want.occ, occupancy_i);
            fails++;
          end
        end
      end
      if (psel && penable && pready && paddr == REG_CAPACITY_ADDR) begin
        if (pwrite) begin
          cap_reg = pwdata[CAP_W-1:0];
        end else if (prdata !== APB_DW'(cap_reg)) begin
          $display("%0t: capacity readback mismatch, expected %0d, actual %0d",
                   $time, cap_reg, prdata);
          fails++;
        end
      end
    end
  end

endmodule

// ===== bench/sorted_priority_queue_top_test.sv =====
// Testbench top for the sorted priority queue: stimulus, capacity phases and verdict.
`timescale 1ns / 1ps

module sorted_priority_queue_top_test;
  import spq_pkg::*;

  localparam int unsigned QUEUE_DEPTH = 64;
  localparam int          PHASES      = 10;
  localparam int          PHASE_ITEMS = 108;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    start_i;
  logic                    busy_o;
  logic                    action_i;
  logic signed [VAL_W-1:0] value_in_i;
  logic                    done_o;
  logic [1:0]              status_o;
  logic signed [VAL_W-1:0] value_out_o;
  logic [OCC_W-1:0]        occupancy_o;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [APB_AW-1:0]       paddr;
  logic [APB_DW-1:0]       pwdata;
  logic [APB_DW-1:0]       prdata;
  logic                    pready;

  int fails;
  int pending;
  int results;
  int overflows;
  int underflows;

  int enq_sent    = 0;
  int deq_sent    = 0;
  int cap_writes  = 0;
  int burst_left  = 1;

  logic [CAP_W-1:0] phase_cap     [PHASES] = '{7'd64, 7'd3, 7'd127, 7'd0, 7'd1,
                                               7'd2, 7'd64, 7'd17, 7'd100, 7'd64};
  int               phase_enq_pct [PHASES] = '{75, 30, 70, 20, 60, 55, 85, 50, 40, 25};

  sorted_priority_queue_top #(
    .CAPACITY(QUEUE_DEPTH)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .action_i    (action_i),
    .value_in_i  (value_in_i),
    .done_o      (done_o),
    .status_o    (status_o),
    .value_out_o (value_out_o),
    .occupancy_o (occupancy_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  spq_result_checker #(
    .CAPACITY(QUEUE_DEPTH)
  ) checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_i       (busy_o),
    .action_i     (action_i),
    .value_in_i   (value_in_i),
    .done_i       (done_o),
    .status_i     (status_o),
    .value_out_i  (value_out_o),
    .occupancy_i  (occupancy_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .fail_count_o (fails),
    .pending_o    (pending),
    .results_o    (results),
    .overflows_o  (overflows),
    .underflows_o (underflows)
  );

  always #10 clk_i = ~clk_i;

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return $urandom_range(0, 8) - 32'd4;
      7: begin
        case ($urandom_range(0, 3))
          0:       return 32'h8000_0000;
          1:       return 32'h7fff_ffff;
          2:       return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      8:       return 32'h8000_0000 + $urandom_range(0, 7);
      default: return 32'h7fff_ffff - $urandom_range(0, 7);
    endcase
  endfunction

  // one command transfer, then maybe a gap between bursts
  task automatic send(action_e act, logic [VAL_W-1:0] v);
    start_i    <= 1'b1;
    action_i   <= act;
    value_in_i <= v;
    do @(posedge clk_i); while (busy_o);
    if (act == ACT_ENQ) enq_sent++;
    else deq_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      if ($urandom_range(0, 3) != 0) begin
        start_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  task automatic apb_transfer(logic wr, logic [CAP_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= REG_CAPACITY_ADDR;
    pwdata  <= APB_DW'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] v);
    wait_drained();
    apb_transfer(1'b1, v);
    cap_writes++;
    apb_transfer(1'b0, '0);
  endtask

  initial begin
    int p;
    int n;
    rst_ni     <= 1'b0;
    start_i    <= 1'b0;
    action_i   <= ACT_ENQ;
    value_in_i <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= REG_CAPACITY_ADDR;
    pwdata     <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    apb_transfer(1'b0, '0);

    // directed: empty queue, extremes, equal values, drain in order
    send(ACT_DEQ, $urandom);
    send(ACT_ENQ, 32'h0000_0000);
    send(ACT_ENQ, 32'h7fff_ffff);
    send(ACT_ENQ, 32'h8000_0000);
    send(ACT_ENQ, 32'hffff_ffff);
    send(ACT_ENQ, 32'h0000_0001);
    send(ACT_ENQ, 32'h0000_0005);
    send(ACT_ENQ, 32'h0000_0005);
    send(ACT_ENQ, 32'hffff_ffff);
    send(ACT_ENQ, 32'h8000_0000);
    for (n = 0; n < 9; n++) send(ACT_DEQ, $urandom);
    send(ACT_DEQ, 32'hffff_ffff);

    // single entry capacity, then zero capacity
    set_capacity(7'd1);
    send(ACT_ENQ, 32'h0000_0003);
    send(ACT_ENQ, 32'h0000_0004);
    send(ACT_DEQ, $urandom);
    set_capacity(7'd0);
    send(ACT_ENQ, 32'h1234_5678);
    send(ACT_DEQ, $urandom);

    // random phases; entries carry over so a lowered capacity starts below occupancy
    phase_cap[7] = CAP_W'($urandom_range(4, 63));
    for (p = 0; p < PHASES; p++) begin
      set_capacity(phase_cap[p]);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(1, 100) <= phase_enq_pct[p]) send(ACT_ENQ, pick_value());
        else send(ACT_DEQ, $urandom);
      end
    end

    wait_drained();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    $display("Sent %0d enqueues and %0d dequeues across %0d capacity settings (0 to 127).",
             enq_sent, deq_sent, cap_writes + 1);
    $display("Checked %0d results, including %0d overflows and %0d underflows.",
             results, overflows, underflows);
    if (fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
